@@ rtl/core/psd_pkg.sv @@
package psd_pkg;

  localparam int COORD_WIDTH     = 24;
  localparam int T_FRACTION_BITS = 16;
  localparam int DIST_W          = 25;

  // Coordinate differences, squares and dot products.
  localparam int DW   = COORD_WIDTH + 1;
  localparam int PW   = 2 * DW;
  localparam int LW   = 2 * COORD_WIDTH + 2;
  localparam int DOTW = 2 * COORD_WIDTH + 3;

  // Projection parameter, scaled offsets and error vector.
  localparam int TW   = T_FRACTION_BITS + 1;
  localparam int MW   = TW + DW;
  localparam int EW   = COORD_WIDTH + 2;
  localparam int SQW  = 2 * EW;

  // Digit-by-digit square root.
  localparam int ROOTW = SQW / 2;
  localparam int SRW   = ROOTW + 3;

  localparam logic [MW-1:0] T_MASK = MW'((64'd1 << T_FRACTION_BITS) - 64'd1);
  localparam logic [TW-1:0] T_ONE  = TW'(64'd1 << T_FRACTION_BITS);

  localparam logic [1:0] SIDE_NONE  = 2'd0;
  localparam logic [1:0] SIDE_START = 2'd1;
  localparam logic [1:0] SIDE_END   = 2'd2;

  typedef enum logic [1:0] {
    TM_DIV,
    TM_ZERO,
    TM_ONE
  } tmode_t;

  typedef struct packed {
    logic                  valid;
    logic [LW-1:0]         len;
    logic [LW-1:0]         rem;
    logic [T_FRACTION_BITS-1:0] t;
    tmode_t                mode;
    logic                  degenerate;
    logic [1:0]            side;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
    logic signed [DW-1:0]  rx;
    logic signed [DW-1:0]  ry;
  } div_t;

  typedef struct packed {
    logic           valid;
    logic [SQW-1:0] n;
    logic           degenerate;
    logic [1:0]     side;
  } sq_t;

  typedef struct packed {
    logic             valid;
    logic [SQW-1:0]   n;
    logic [ROOTW:0]   rem;
    logic [ROOTW-1:0] root;
    logic             degenerate;
    logic [1:0]       side;
  } sqrt_t;

endpackage

@@ rtl/core/psd_front.sv @@
module psd_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] point_x,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] point_y,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] start_x,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] start_y,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] end_x,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] end_y,
  output psd_pkg::div_t                          div_out
);
  import psd_pkg::*;

  logic                   v1, v2, v3;
  logic signed [DW-1:0]   dx1, dy1, rx1, ry1;
  logic signed [DW-1:0]   dx2, dy2, rx2, ry2;
  logic signed [DW-1:0]   dx3, dy3, rx3, ry3;
  logic signed [PW-1:0]   xx2, yy2, rxdx2, rydy2;
  logic [LW-1:0]          len3;
  logic signed [DOTW-1:0] dot3;
  div_t                   div_next;
  logic                   neg, ge, gt, degen;

  always_ff @(posedge clk) begin
    if (en) begin
      v1  <= in_valid;
      dx1 <= DW'(end_x) - DW'(start_x);
      dy1 <= DW'(end_y) - DW'(start_y);
      rx1 <= DW'(point_x) - DW'(start_x);
      ry1 <= DW'(point_y) - DW'(start_y);

      v2    <= v1;
      xx2   <= dx1 * dx1;
      yy2   <= dy1 * dy1;
      rxdx2 <= rx1 * dx1;
      rydy2 <= ry1 * dy1;
      dx2 <= dx1; dy2 <= dy1; rx2 <= rx1; ry2 <= ry1;

      v3   <= v2;
      len3 <= LW'($unsigned(xx2)) + LW'($unsigned(yy2));
      dot3 <= DOTW'(rxdx2) + DOTW'(rydy2);
      dx3 <= dx2; dy3 <= dy2; rx3 <= rx2; ry3 <= ry2;

      div_out <= div_next;
    end
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      div_out.valid <= 1'b0;
    end
  end

  always_comb begin
    degen = (len3 == '0);
    neg   = dot3[DOTW-1];
    ge    = !neg && (dot3[DOTW-2:0] >= len3);
    gt    = !neg && (dot3[DOTW-2:0] > len3);

    div_next            = '0;
    div_next.valid      = v3;
    div_next.len        = len3;
    div_next.degenerate = degen;
    div_next.dx = dx3; div_next.dy = dy3; div_next.rx = rx3; div_next.ry = ry3;
    div_next.t          = '0;
    if (degen || neg) begin
      div_next.mode = TM_ZERO;
    end else if (ge) begin
      div_next.mode = TM_ONE;
    end else begin
      div_next.mode = TM_DIV;
      div_next.rem  = dot3[LW-1:0];
    end
    // A zero-length segment reports no clamping at all.
    if (degen) begin
      div_next.side = SIDE_NONE;
    end else if (neg) begin
      div_next.side = SIDE_START;
    end else if (gt) begin
      div_next.side = SIDE_END;
    end else begin
      div_next.side = SIDE_NONE;
    end
  end

endmodule

@@ rtl/core/psd_div.sv @@
module psd_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  psd_pkg::div_t div_in,
  output psd_pkg::div_t div_out
);
  import psd_pkg::*;

  div_t stage [0:T_FRACTION_BITS];

  assign stage[0] = div_in;
  assign div_out  = stage[T_FRACTION_BITS];

  // One quotient bit per stage, restoring division.
  for (genvar k = 0; k < T_FRACTION_BITS; k++) begin : g_step
    logic [LW:0] rem2;
    logic        take;
    div_t        nxt;

    always_comb begin
      rem2 = {stage[k].rem, 1'b0};
      take = (rem2 >= {1'b0, stage[k].len});
      nxt  = stage[k];
      if (take) begin
        nxt.rem = LW'(rem2 - {1'b0, stage[k].len});
      end else begin
        nxt.rem = rem2[LW-1:0];
      end
      nxt.t = {stage[k].t[T_FRACTION_BITS-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage[k+1] <= nxt;
      end
      if (rst) begin
        stage[k+1].valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/psd_scale.sv @@
module psd_scale (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  psd_pkg::div_t div_in,
  output psd_pkg::sq_t  sq_out
);
  import psd_pkg::*;

  logic                 va, vb, vc;
  logic [TW-1:0]        t_full;
  logic [DW-1:0]        ax_mag, ay_mag;
  logic [MW-1:0]        mx, my;
  logic                 nx, ny;
  logic signed [DW-1:0] rxa, rya;
  logic signed [EW-1:0] sx, sy;
  logic signed [EW-1:0] ex, ey;
  logic [SQW-1:0]       qx, qy;
  logic                 dg_a, dg_b, dg_c;
  logic [1:0]           sd_a, sd_b, sd_c;

  always_comb begin
    case (div_in.mode)
      TM_ONE:  t_full = T_ONE;
      TM_ZERO: t_full = '0;
      TM_DIV:  t_full = {1'b0, div_in.t};
      default: t_full = '0;
    endcase
    ax_mag = div_in.dx[DW-1] ? DW'(-div_in.dx) : DW'(div_in.dx);
    ay_mag = div_in.dy[DW-1] ? DW'(-div_in.dy) : DW'(div_in.dy);
    // Negative offsets round toward minus infinity on the coordinate grid.
    sx = nx ? -EW'((mx + T_MASK) >> T_FRACTION_BITS) : EW'(mx >> T_FRACTION_BITS);
    sy = ny ? -EW'((my + T_MASK) >> T_FRACTION_BITS) : EW'(my >> T_FRACTION_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      va   <= div_in.valid;
      mx   <= MW'(t_full) * MW'(ax_mag);
      my   <= MW'(t_full) * MW'(ay_mag);
      nx   <= div_in.dx[DW-1];
      ny   <= div_in.dy[DW-1];
      rxa  <= div_in.rx;
      rya  <= div_in.ry;
      dg_a <= div_in.degenerate;
      sd_a <= div_in.side;

      vb   <= va;
      ex   <= EW'(rxa) - sx;
      ey   <= EW'(rya) - sy;
      dg_b <= dg_a;
      sd_b <= sd_a;

      // The squares are taken at the full register width so no bits are lost.
      vc   <= vb;
      qx   <= ex * ex;
      qy   <= ey * ey;
      dg_c <= dg_b;
      sd_c <= sd_b;

      sq_out.valid      <= vc;
      sq_out.n          <= qx + qy;
      sq_out.degenerate <= dg_c;
      sq_out.side       <= sd_c;
    end
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      sq_out.valid <= 1'b0;
    end
  end

endmodule

@@ rtl/core/psd_sqrt.sv @@
module psd_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  psd_pkg::sq_t   sq_in,
  output psd_pkg::sqrt_t sqrt_out
);
  import psd_pkg::*;

  sqrt_t stage [0:ROOTW];

  always_comb begin
    stage[0]            = '0;
    stage[0].valid      = sq_in.valid;
    stage[0].n          = sq_in.n;
    stage[0].degenerate = sq_in.degenerate;
    stage[0].side       = sq_in.side;
  end

  assign sqrt_out = stage[ROOTW];

  // Each stage brings down two bits of the radicand and settles one root bit.
  for (genvar k = 0; k < ROOTW; k++) begin : g_step
    logic [SRW-1:0] cur, trial;
    logic           take;
    sqrt_t          nxt;

    always_comb begin
      cur   = {stage[k].rem, stage[k].n[SQW-1-2*k -: 2]};
      trial = SRW'({stage[k].root, 2'b01});
      take  = (cur >= trial);
      nxt   = stage[k];
      if (take) begin
        nxt.rem = (ROOTW+1)'(cur - trial);
      end else begin
        nxt.rem = cur[ROOTW:0];
      end
      nxt.root = {stage[k].root[ROOTW-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage[k+1] <= nxt;
      end
      if (rst) begin
        stage[k+1].valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/point_segment_distance.sv @@
// Point to segment distance, 2D, signed Q15.8 coordinates.
// Input channel: in_valid / in_stall carry one beat of point, start and end
// coordinates. Output channel: out_valid / out_stall carry one beat of
// distance (unsigned Q.8, floor of the root), degenerate and clamp_side.
// Every input beat produces exactly one output beat, in order.
// The pipeline has 4 stages of differences, products and classification,
// 16 stages of restoring division (one bit of t per stage), 4 stages for the
// closest point and squared error, and 26 stages of digit-by-digit square
// root (one root bit per stage). The last root stage is the output register.
// Throughput is one beat per cycle while unstalled. While out_stall holds a
// waiting result the whole pipeline freezes and in_stall is raised; empty
// stages are not squeezed out. Synchronous reset clears every stage's valid
// bit, so the output shows no beat after reset; no clearing pass is needed.
module point_segment_distance (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] point_x,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] point_y,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] start_x,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] start_y,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] end_x,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] end_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [psd_pkg::DIST_W-1:0]             distance,
  output logic                                   degenerate,
  output logic [1:0]                             clamp_side
);
  import psd_pkg::*;

  logic  en;
  div_t  front_q, div_q;
  sq_t   sq_q;
  sqrt_t root_q;

  assign en       = !(root_q.valid && out_stall);
  assign in_stall = !en;

  psd_front u_front (
    .clk, .rst, .en, .in_valid,
    .point_x, .point_y, .start_x, .start_y, .end_x, .end_y,
    .div_out (front_q)
  );

  psd_div u_div (
    .clk, .rst, .en,
    .div_in  (front_q),
    .div_out (div_q)
  );

  psd_scale u_scale (
    .clk, .rst, .en,
    .div_in (div_q),
    .sq_out (sq_q)
  );

  psd_sqrt u_sqrt (
    .clk, .rst, .en,
    .sq_in    (sq_q),
    .sqrt_out (root_q)
  );

  assign out_valid  = root_q.valid;
  assign distance   = root_q.root[DIST_W-1:0];
  assign degenerate = root_q.degenerate;
  assign clamp_side = root_q.side;

endmodule

@@ rtl/core/psd_checker.sv @@
module psd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [psd_pkg::DIST_W-1:0] distance,
  input logic                       degenerate,
  input logic [1:0]                 clamp_side
);
  import psd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(distance) && $stable(clamp_side))
    else $error("stalled output beat changed");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the waiting output beat");

  a_degen_side: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> clamp_side == SIDE_NONE)
    else $error("degenerate segment reported a clamped end");

  a_side_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> clamp_side == SIDE_NONE || clamp_side == SIDE_START ||
                  clamp_side == SIDE_END)
    else $error("clamp side code out of range");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat shown after reset");

endmodule

bind point_segment_distance psd_checker u_psd_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .distance, .degenerate, .clamp_side
);
